[rtl/core/pllsp_pkg.sv]
`default_nettype none

package pllsp_pkg;

  localparam int DATA_BITS_DEF = 20;
  localparam int ADDR_BITS_DEF = 4;

  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_REF_DIVIDER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_FULL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_REDUCE = 2'd2;

  localparam logic [CFG_W-1:0] REF_DIVIDER_RST = 20'd400;

  localparam logic [1:0] CMD_TICK      = 2'd0;
  localparam logic [1:0] CMD_SET_CHAN  = 2'd1;
  localparam logic [1:0] CMD_SET_POWER = 2'd2;

  localparam int REG_ADDR_REF   = 0;
  localparam int REG_ADDR_CHAN  = 1;
  localparam int REG_ADDR_POWER = 7;

  typedef struct packed {
    logic [1:0]  command;
    logic [14:0] channel_mhz;
    logic        low_power;
  } in_req_t;

  typedef struct packed {
    logic serial_data;
    logic serial_clock;
    logic latch_enable;
    logic busy_res;
    logic rejected;
  } out_res_t;

endpackage

`default_nettype wire

[rtl/core/pll_synth_serial_programmer_core.sv]
`default_nettype none

// Three-wire serial programmer for a frequency synthesizer. Every accepted
// request is one sequencer tick and yields exactly one result: the data,
// clock and latch line levels after that tick, plus busy and rejected flags.
// A set-channel request sends the reference divider word to register 0 and
// then (N<<7)|A, with v = mhz*25, N = v/64, A = v%64, to register 1; a
// set-power request sends one of two power words to register 7. Each frame
// is one latch-low tick, then ADDR_BITS+1+DATA_BITS bits LSB first (address,
// write bit, data), each one clock-high and one clock-low tick, then latch
// high; a queued frame follows right after the latch-high tick. Set requests
// while busy are refused. Throughput is one request per clock while the
// two-entry output buffer is not full; each result is registered into it, so a
// request is still taken while one result waits. Config writes are registered.
module pll_synth_serial_programmer_core
  import pllsp_pkg::*;
#(
  parameter int DATA_BITS = DATA_BITS_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_req_t              in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_res_t                  out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  localparam int FRAME_BITS = ADDR_BITS + 1 + DATA_BITS;
  localparam int CNT_W      = $clog2(FRAME_BITS + 1);

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_LATCH_LOW = 3'd1;
  localparam logic [2:0] PH_CLK_HIGH  = 3'd2;
  localparam logic [2:0] PH_CLK_LOW   = 3'd3;
  localparam logic [2:0] PH_GAP       = 3'd4;

  localparam logic [ADDR_BITS-1:0] ADDR_REF   = ADDR_BITS'(REG_ADDR_REF);
  localparam logic [ADDR_BITS-1:0] ADDR_CHAN  = ADDR_BITS'(REG_ADDR_CHAN);
  localparam logic [ADDR_BITS-1:0] ADDR_POWER = ADDR_BITS'(REG_ADDR_POWER);

  function automatic logic [FRAME_BITS-1:0] make_frame(
    input logic [ADDR_BITS-1:0] addr,
    input logic [DATA_BITS-1:0] data
  );
    return {data, 1'b1, addr};
  endfunction

  logic [CFG_W-1:0] ref_word_r, pwr_full_r, pwr_reduce_r;

  logic [FRAME_BITS-1:0] shift_r, shift_nxt;
  logic [FRAME_BITS-1:0] queued_r, queued_nxt;
  logic                  qvalid_r, qvalid_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      count_inc;
  logic [2:0]            phase_r, phase_nxt;
  logic                  pin_data_r, pin_data_nxt;
  logic                  pin_clk_r, pin_clk_nxt;
  logic                  pin_latch_r, pin_latch_nxt;

  logic                  push, pop, busy, is_set;
  logic [19:0]           vco;
  logic [CFG_W-1:0]      power_sel;
  out_res_t              res;
  out_res_t              q0_r, q0_nxt, q1_r, q1_nxt;
  logic [1:0]            fill_r, fill_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_word_r   <= REF_DIVIDER_RST;
      pwr_full_r   <= '0;
      pwr_reduce_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REF_DIVIDER:  ref_word_r   <= cfg_wdata;
        CFG_POWER_FULL:   pwr_full_r   <= cfg_wdata;
        CFG_POWER_REDUCE: pwr_reduce_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign busy      = (phase_r != PH_IDLE) || qvalid_r;
  assign is_set    = (in_data.command == CMD_SET_CHAN) || (in_data.command == CMD_SET_POWER);
  assign vco       = 20'(in_data.channel_mhz) * 20'd25;
  assign power_sel = in_data.low_power ? pwr_reduce_r : pwr_full_r;
  assign count_inc = count_r + CNT_W'(1);

  always_comb begin
    shift_nxt     = shift_r;
    queued_nxt    = queued_r;
    qvalid_nxt    = qvalid_r;
    count_nxt     = count_r;
    phase_nxt     = phase_r;
    pin_data_nxt  = pin_data_r;
    pin_clk_nxt   = pin_clk_r;
    pin_latch_nxt = pin_latch_r;
    if (is_set && !busy) begin
      if (in_data.command == CMD_SET_CHAN) begin
        shift_nxt  = make_frame(ADDR_REF, DATA_BITS'(ref_word_r));
        queued_nxt = make_frame(ADDR_CHAN, DATA_BITS'({vco[19:6], 1'b0, vco[5:0]}));
        qvalid_nxt = 1'b1;
      end else begin
        shift_nxt  = make_frame(ADDR_POWER, DATA_BITS'(power_sel));
        qvalid_nxt = 1'b0;
      end
      count_nxt     = '0;
      phase_nxt     = PH_LATCH_LOW;
      pin_clk_nxt   = 1'b0;
      pin_latch_nxt = 1'b0;
    end else begin
      unique case (phase_r)
        PH_LATCH_LOW: begin
          count_nxt     = '0;
          phase_nxt     = PH_CLK_HIGH;
          pin_data_nxt  = shift_r[0];
          pin_clk_nxt   = 1'b1;
          pin_latch_nxt = 1'b0;
        end
        PH_CLK_HIGH: begin
          phase_nxt     = PH_CLK_LOW;
          pin_clk_nxt   = 1'b0;
          pin_latch_nxt = 1'b0;
        end
        PH_CLK_LOW: begin
          if (count_inc < CNT_W'(FRAME_BITS)) begin
            count_nxt     = count_inc;
            shift_nxt     = shift_r >> 1;
            phase_nxt     = PH_CLK_HIGH;
            pin_data_nxt  = shift_r[1];
            pin_clk_nxt   = 1'b1;
            pin_latch_nxt = 1'b0;
          end else begin
            count_nxt     = '0;
            pin_clk_nxt   = 1'b0;
            pin_latch_nxt = 1'b1;
            phase_nxt     = qvalid_r ? PH_GAP : PH_IDLE;
          end
        end
        PH_GAP: begin
          shift_nxt     = queued_r;
          qvalid_nxt    = 1'b0;
          count_nxt     = '0;
          phase_nxt     = PH_LATCH_LOW;
          pin_clk_nxt   = 1'b0;
          pin_latch_nxt = 1'b0;
        end
        default: begin
          phase_nxt     = PH_IDLE;
          pin_latch_nxt = 1'b1;
        end
      endcase
    end
    res.serial_data  = pin_data_nxt;
    res.serial_clock = pin_clk_nxt;
    res.latch_enable = pin_latch_nxt;
    res.busy_res     = (phase_nxt != PH_IDLE) || qvalid_nxt;
    res.rejected     = is_set && busy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r     <= '0;
      queued_r    <= '0;
      qvalid_r    <= 1'b0;
      count_r     <= '0;
      phase_r     <= PH_IDLE;
      pin_data_r  <= 1'b0;
      pin_clk_r   <= 1'b0;
      pin_latch_r <= 1'b1;
    end else if (push) begin
      shift_r     <= shift_nxt;
      queued_r    <= queued_nxt;
      qvalid_r    <= qvalid_nxt;
      count_r     <= count_nxt;
      phase_r     <= phase_nxt;
      pin_data_r  <= pin_data_nxt;
      pin_clk_r   <= pin_clk_nxt;
      pin_latch_r <= pin_latch_nxt;
    end
  end

  assign in_ready  = (fill_r != 2'd2);
  assign out_valid = (fill_r != 2'd0);
  assign out_data  = q0_r;

  always_comb begin
    q0_nxt   = q0_r;
    q1_nxt   = q1_r;
    fill_nxt = fill_r;
    if (push && !pop) begin
      if (fill_r == 2'd0) begin
        q0_nxt = res;
      end else begin
        q1_nxt = res;
      end
      fill_nxt = fill_r + 2'd1;
    end else if (pop && !push) begin
      q0_nxt   = q1_r;
      fill_nxt = fill_r - 2'd1;
    end else if (pop && push) begin
      if (fill_r == 2'd1) begin
        q0_nxt = res;
      end else begin
        q0_nxt = q1_r;
        q1_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
    if (!rst_n) begin
      fill_r <= 2'd0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

endmodule

`default_nettype wire

[bench/pll_synth_serial_programmer_core_test.sv]
`timescale 1ns / 100ps

module pll_synth_serial_programmer_core_test;
  import pllsp_pkg::*;

  localparam int FRAME_W = ADDR_BITS_DEF + 1 + DATA_BITS_DEF;
  localparam logic [1:0] CMD_RESERVED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int DIR_ROWS = 21;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 150;
  localparam int LONG_HOLD = 300;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_LATCH_LOW,
    SEQ_CLK_HIGH,
    SEQ_CLK_LOW,
    SEQ_GAP
  } seq_phase_t;

  typedef struct packed {
    in_req_t    rq;
    logic [7:0] reps;
    logic       lit_ok;
    out_res_t   lit;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_req_t in_data;
  logic out_valid;
  logic out_ready;
  out_res_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  logic lit_ok;
  out_res_t lit_res;

  logic [DATA_BITS_DEF-1:0] ref_word;
  logic [DATA_BITS_DEF-1:0] pwr_full;
  logic [DATA_BITS_DEF-1:0] pwr_reduced;
  logic [FRAME_W-1:0] frame_word;
  logic [FRAME_W-1:0] pend_word;
  logic pend_valid;
  logic [4:0] bit_idx;
  seq_phase_t seq_phase;
  logic line_data;
  logic line_clk;
  logic line_latch;

  out_res_t line_levels_q[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit idle_on = 1'b1;
  bit hold_off_req = 1'b0;
  dir_row_t directed_rows [0:DIR_ROWS-1];

  pll_synth_serial_programmer_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [FRAME_W-1:0] build_frame(input logic [31:0] addr,
                                                     input logic [DATA_BITS_DEF-1:0] data);
    return {data, 1'b1, addr[ADDR_BITS_DEF-1:0]};
  endfunction

  task automatic drive_line_bit();
    line_data = frame_word[bit_idx];
    line_clk = 1'b1;
    line_latch = 1'b0;
  endtask

  task automatic next_line_levels(input in_req_t rq, output out_res_t rs);
    logic busy;
    logic refused;
    logic is_set;
    logic [31:0] v;
    logic [31:0] w;
    busy = (seq_phase != SEQ_IDLE) || pend_valid;
    is_set = (rq.command == CMD_SET_CHAN) || (rq.command == CMD_SET_POWER);
    refused = 1'b0;
    if (is_set && !busy) begin
      if (rq.command == CMD_SET_CHAN) begin
        v = 32'(rq.channel_mhz) * 32'd25;
        w = ((v / 32'd64) << 7) | (v % 32'd64);
        frame_word = build_frame(REG_ADDR_REF, ref_word);
        pend_word = build_frame(REG_ADDR_CHAN, w[DATA_BITS_DEF-1:0]);
        pend_valid = 1'b1;
      end else begin
        frame_word = build_frame(REG_ADDR_POWER, rq.low_power ? pwr_reduced : pwr_full);
        pend_valid = 1'b0;
      end
      bit_idx = '0;
      seq_phase = SEQ_LATCH_LOW;
      line_clk = 1'b0;
      line_latch = 1'b0;
    end else begin
      refused = is_set;
      case (seq_phase)
        SEQ_LATCH_LOW: begin
          bit_idx = '0;
          seq_phase = SEQ_CLK_HIGH;
          drive_line_bit();
        end
        SEQ_CLK_HIGH: begin
          seq_phase = SEQ_CLK_LOW;
          line_clk = 1'b0;
          line_latch = 1'b0;
        end
        SEQ_CLK_LOW: begin
          bit_idx = bit_idx + 5'd1;
          if (bit_idx < FRAME_W) begin
            seq_phase = SEQ_CLK_HIGH;
            drive_line_bit();
          end else begin
            bit_idx = '0;
            line_clk = 1'b0;
            line_latch = 1'b1;
            seq_phase = pend_valid ? SEQ_GAP : SEQ_IDLE;
          end
        end
        SEQ_GAP: begin
          frame_word = pend_word;
          pend_valid = 1'b0;
          bit_idx = '0;
          seq_phase = SEQ_LATCH_LOW;
          line_clk = 1'b0;
          line_latch = 1'b0;
        end
        default: begin
          seq_phase = SEQ_IDLE;
          line_clk = 1'b0;
          line_latch = 1'b1;
        end
      endcase
    end
    rs.serial_data = line_data;
    rs.serial_clock = line_clk;
    rs.latch_enable = line_latch;
    rs.busy_res = (seq_phase != SEQ_IDLE) || pend_valid;
    rs.rejected = refused;
  endtask

  task automatic check_field(input string name, input logic exp_v, input logic act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0b, got %0b", name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    out_res_t want;
    out_res_t pred;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_REF_DIVIDER:  ref_word = cfg_wdata;
          CFG_POWER_FULL:   pwr_full = cfg_wdata;
          CFG_POWER_REDUCE: pwr_reduced = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (line_levels_q.size() == 0) begin
          $error("result with no request outstanding: %b", out_data);
          mismatch_count++;
        end else begin
          want = line_levels_q.pop_front();
          check_field("serial_data", want.serial_data, out_data.serial_data);
          check_field("serial_clock", want.serial_clock, out_data.serial_clock);
          check_field("latch_enable", want.latch_enable, out_data.latch_enable);
          check_field("busy_res", want.busy_res, out_data.busy_res);
          check_field("rejected", want.rejected, out_data.rejected);
        end
      end
      if (in_valid && in_ready) begin
        next_line_levels(in_data, pred);
        line_levels_q.push_back(lit_ok ? lit_res : pred);
      end
    end
  end

  initial begin
    out_ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_request(input in_req_t rq, input logic has_lit, input out_res_t lit);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= rq;
    lit_ok <= has_lit;
    lit_res <= lit;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (line_levels_q.size() != 0);
  endtask

  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  function automatic in_req_t random_request();
    in_req_t rq;
    rq.command = 2'($urandom_range(0, 3));
    rq.channel_mhz = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 20000));
    rq.low_power = 1'($urandom);
    return rq;
  endfunction

  task automatic send_random_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned ticks;
    int unsigned k;
    in_req_t rq;
    in_req_t fill;
    sent = 0;
    while (sent < n_items) begin
      rq = random_request();
      if ($urandom_range(0, 9) < 7) begin
        rq.command = $urandom_range(0, 1) ? CMD_SET_CHAN : CMD_SET_POWER;
        ticks = (rq.command == CMD_SET_CHAN) ? 4 * FRAME_W + 1 : 2 * FRAME_W;
        ticks = ticks - 2 + $urandom_range(0, 4);
        send_request(rq, 1'b0, '0);
        sent++;
        for (k = 0; k < ticks; k++) begin
          fill = random_request();
          fill.command = ($urandom_range(0, 11) == 0) ? 2'($urandom_range(1, 3)) : CMD_TICK;
          send_request(fill, 1'b0, '0);
          sent++;
        end
      end else begin
        send_request(rq, 1'b0, '0);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    int unsigned row;
    int unsigned r;
    int unsigned ph;
    int unsigned i;
    ref_word = REF_DIVIDER_RST;
    pwr_full = '0;
    pwr_reduced = '0;
    frame_word = '0;
    pend_word = '0;
    pend_valid = 1'b0;
    bit_idx = '0;
    seq_phase = SEQ_IDLE;
    line_data = 1'b0;
    line_clk = 1'b0;
    line_latch = 1'b1;

    directed_rows = '{
      '{'{CMD_TICK,      15'd0,     1'b0}, 8'd1,   1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0}},
      '{'{CMD_RESERVED,  15'd32767, 1'b1}, 8'd1,   1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0}},
      '{'{CMD_SET_POWER, 15'd0,     1'b0}, 8'd1,   1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0}},
      '{'{CMD_TICK,      15'd0,     1'b0}, 8'd1,   1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0}},
      '{'{CMD_SET_CHAN,  15'd20000, 1'b0}, 8'd1,   1'b1, '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1}},
      '{'{CMD_SET_POWER, 15'd0,     1'b1}, 8'd1,   1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1}},
      '{'{CMD_TICK,      15'd0,     1'b0}, 8'd1,   1'b1, '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0}},
      '{'{CMD_TICK,      15'd0,     1'b0}, 8'd1,   1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0}},
      '{'{CMD_TICK,      15'd0,     1'b0}, 8'd1,   1'b1, '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0}},
      '{'{CMD_TICK,      15'd0,     1'b0}, 8'd1,   1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0}},
      '{'{CMD_TICK,      15'd0,     1'b0}, 8'd1,   1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0}},
      '{'{CMD_TICK,      15'd0,     1'b0}, 8'd50,  1'b0, '0},
      '{'{CMD_TICK,      15'd0,     1'b0}, 8'd1,   1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0}},
      '{'{CMD_SET_CHAN,  15'd0,     1'b0}, 8'd1,   1'b0, '0},
      '{'{CMD_TICK,      15'd0,     1'b0}, 8'd110, 1'b0, '0},
      '{'{CMD_SET_CHAN,  15'd32767, 1'b1}, 8'd1,   1'b0, '0},
      '{'{CMD_TICK,      15'd0,     1'b0}, 8'd110, 1'b0, '0},
      '{'{CMD_SET_CHAN,  15'd20000, 1'b0}, 8'd1,   1'b0, '0},
      '{'{CMD_TICK,      15'd0,     1'b0}, 8'd110, 1'b0, '0},
      '{'{CMD_SET_POWER, 15'd0,     1'b1}, 8'd1,   1'b0, '0},
      '{'{CMD_TICK,      15'd0,     1'b0}, 8'd60,  1'b0, '0}
    };

    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    lit_ok <= 1'b0;
    lit_res <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (row = 0; row < DIR_ROWS; row++) begin
      for (r = 0; r < directed_rows[row].reps; r++) begin
        send_request(directed_rows[row].rq, directed_rows[row].lit_ok, directed_rows[row].lit);
      end
    end

    for (ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      for (i = 0; i < 3; i++) begin
        if (ph == 0) begin
          write_setting(CFG_IDX_W'(i), '1);
        end else if (ph == 1) begin
          write_setting(CFG_IDX_W'(i), '0);
        end else begin
          write_setting(CFG_IDX_W'(i), CFG_W'($urandom));
        end
      end
      write_setting(CFG_UNUSED, CFG_W'($urandom));
      cfg_we <= 1'b0;
      idle_on = (ph != PHASES - 1);
      if (ph == 2) hold_off_req = 1'b1;
      send_random_traffic(PHASE_ITEMS);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && line_levels_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
